// ----- hdl/delu_pkg.sv -----
// ----------------------------------------------------------------------------
// DELU package
// Shared constants, register codes and pipeline types of the DELU activation unit.
// ----------------------------------------------------------------------------
package delu_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int LN2_Q      = 45426;        // ln 2 in Q16.16
   localparam int RECIP_LN2  = 94548;        // floor(2^32 / LN2_Q)
   localparam int U_OFFSET   = 50 * LN2_Q;   // bias that makes the reduced exponent non-negative
   localparam int T_BIG      = 46 * LN2_Q;   // exponents from here on overflow the data range
   localparam int SHIFT_BIAS = 64;           // q - SHIFT_BIAS is the final scaling shift
   localparam int ONE_Q      = 65536;        // 1.0 in Q16.16
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
   localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VMIN = 32'sh8000_0000;

   localparam logic signed [31:0] GAIN_A_RST  = 32'sd65536;
   localparam logic signed [31:0] RECIP_B_RST = 32'sd32768;
   localparam logic signed [31:0] KNEE_RST    = 32'sd82341;

   typedef enum logic [1:0] {
      CSR_GAIN_A  = 2'd0,
      CSR_RECIP_B = 2'd1,
      CSR_KNEE    = 2'd2
   } csr_index_type;

   // Information that rides along the exponent chain with each element.
   typedef struct packed {
      logic               last;
      logic               done;   // result already final (pass-through or backward)
      logic               sat;
      logic signed [31:0] res;
      logic               big;    // exp overflows for sure
      logic               zero;   // exp underflows to zero
      logic signed [7:0]  shift;  // scaling shift applied to the series value
   } delu_side_type;

   typedef struct packed {
      logic [31:0]   p;      // series value in Q2.30
      logic [29:0]   r30;    // reduced argument in Q0.30
      delu_side_type side;
   } delu_cell_data_type;

endpackage

// ----- hdl/delu_ifs.sv -----
// ----------------------------------------------------------------------------
// DELU channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface delu_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic signed [31:0] sample;
   logic signed [31:0] grad_in;
   logic               last_in;

   modport source (output valid, cmd, sample, grad_in, last_in, input ready);
   modport sink   (input valid, cmd, sample, grad_in, last_in, output ready);
endinterface

interface delu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result;
   logic               saturated;
   logic               last_out;

   modport source (output valid, result, saturated, last_out, input ready);
   modport sink   (input valid, result, saturated, last_out, output ready);
endinterface

interface delu_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/delu_front.sv -----
// ----------------------------------------------------------------------------
// DELU front end
// Gain products, exponent range reduction and the complete backward path.
// ----------------------------------------------------------------------------
module delu_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic                         in_cmd,
   input  logic signed [31:0]           in_sample,
   input  logic signed [31:0]           in_grad,
   input  logic                         in_last,
   input  logic signed [31:0]           gain_a,
   input  logic signed [31:0]           recip_b,
   input  logic signed [31:0]           knee,
   output logic                         out_valid,
   output delu_pkg::delu_cell_data_type out_data
);

   // Stage 0: products with the gain.
   logic               f0_valid_ff, f0_cmd_ff, f0_last_ff, f0_pass_ff;
   logic signed [31:0] f0_x_ff, f0_g_ff;
   logic signed [63:0] f0_ax_ff, f0_arb_ff;

   // Stage 1: scaled exponent, range checks and backward sum.
   logic               f1_valid_ff, f1_cmd_ff, f1_last_ff, f1_pass_ff;
   logic signed [31:0] f1_x_ff, f1_g_ff;
   logic               f1_big_ff, f1_zero_ff;
   logic [22:0]        f1_u_ff;
   logic signed [48:0] f1_sum_ff;
   logic signed [47:0] f1_t_in, f1_arbs_in;
   logic signed [48:0] f1_sum_in;
   logic signed [47:0] f1_ub_in;

   // Stage 2: reciprocal estimate and backward partial products.
   logic               f2_valid_ff, f2_cmd_ff, f2_last_ff, f2_pass_ff;
   logic signed [31:0] f2_x_ff, f2_g_ff;
   logic               f2_big_ff, f2_zero_ff;
   logic [22:0]        f2_u_ff;
   logic [39:0]        f2_um_ff;
   logic signed [56:0] f2_pl_ff, f2_ph_ff;

   // Stage 3: quotient correction and backward clipping.
   logic                         f3_valid_ff;
   delu_pkg::delu_cell_data_type f3_data_ff, f3_data_in;
   logic [6:0]                   qe, q;
   logic [22:0]                  rem;
   logic [15:0]                  r;
   logic signed [80:0]           full;
   logic signed [64:0]           scaled;
   logic signed [31:0]           bres;
   logic                         bsat;

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (en) begin
         f0_valid_ff <= in_valid;
         f1_valid_ff <= f0_valid_ff;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_comb begin
      f1_t_in    = f0_ax_ff[63:16];
      f1_arbs_in = f0_arb_ff[63:16];
      f1_sum_in  = 49'(f1_t_in) + 49'(f1_arbs_in);
      f1_ub_in   = f1_t_in + 48'(delu_pkg::U_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f0_cmd_ff  <= in_cmd;
         f0_last_ff <= in_last;
         f0_pass_ff <= in_sample > knee;
         f0_x_ff    <= in_sample;
         f0_g_ff    <= in_grad;
         f0_ax_ff   <= 64'(gain_a) * 64'(in_sample);
         f0_arb_ff  <= 64'(gain_a) * 64'(recip_b);

         f1_cmd_ff  <= f0_cmd_ff;
         f1_last_ff <= f0_last_ff;
         f1_pass_ff <= f0_pass_ff;
         f1_x_ff    <= f0_x_ff;
         f1_g_ff    <= f0_g_ff;
         f1_big_ff  <= f1_t_in >= 48'(delu_pkg::T_BIG);
         f1_zero_ff <= f1_t_in < -48'(delu_pkg::U_OFFSET);
         f1_u_ff    <= f1_ub_in[22:0];
         f1_sum_ff  <= f1_sum_in;

         f2_cmd_ff  <= f1_cmd_ff;
         f2_last_ff <= f1_last_ff;
         f2_pass_ff <= f1_pass_ff;
         f2_x_ff    <= f1_x_ff;
         f2_g_ff    <= f1_g_ff;
         f2_big_ff  <= f1_big_ff;
         f2_zero_ff <= f1_zero_ff;
         f2_u_ff    <= f1_u_ff;
         f2_um_ff   <= 40'(f1_u_ff) * 40'(delu_pkg::RECIP_LN2);
         f2_pl_ff   <= 57'(f1_g_ff) * 57'($signed({1'b0, f1_sum_ff[23:0]}));
         f2_ph_ff   <= 57'(f1_g_ff) * 57'($signed(f1_sum_ff[48:24]));

         f3_data_ff <= f3_data_in;
      end
   end

   always_comb begin
      // The estimate is at most one below the true quotient.
      qe  = f2_um_ff[38:32];
      rem = f2_u_ff - 23'(qe * 7'(1) * 23'(delu_pkg::LN2_Q));
      if (rem >= 23'(delu_pkg::LN2_Q)) begin
         q = qe + 7'd1;
         r = 16'(rem - 23'(delu_pkg::LN2_Q));
      end else begin
         q = qe;
         r = rem[15:0];
      end

      full   = (81'(f2_ph_ff) <<< 24) + 81'(f2_pl_ff);
      scaled = full[80:16];
      if (scaled > 65'(delu_pkg::VMAX)) begin
         bres = delu_pkg::VMAX;
         bsat = 1'b1;
      end else if (scaled < 65'(delu_pkg::VMIN)) begin
         bres = delu_pkg::VMIN;
         bsat = 1'b1;
      end else begin
         bres = scaled[31:0];
         bsat = 1'b0;
      end

      f3_data_in.p          = delu_pkg::ONE_Q30;
      f3_data_in.r30        = {r, 14'd0};
      f3_data_in.side.last  = f2_last_ff;
      f3_data_in.side.big   = f2_big_ff;
      f3_data_in.side.zero  = f2_zero_ff;
      f3_data_in.side.shift = $signed(8'(q) - 8'(delu_pkg::SHIFT_BIAS));
      if (f2_pass_ff) begin
         f3_data_in.side.done = 1'b1;
         f3_data_in.side.sat  = 1'b0;
         f3_data_in.side.res  = f2_cmd_ff ? f2_g_ff : f2_x_ff;
      end else if (f2_cmd_ff) begin
         f3_data_in.side.done = 1'b1;
         f3_data_in.side.sat  = bsat;
         f3_data_in.side.res  = bres;
      end else begin
         f3_data_in.side.done = 1'b0;
         f3_data_in.side.sat  = 1'b0;
         f3_data_in.side.res  = '0;
      end
   end

   assign out_valid = f3_valid_ff;
   assign out_data  = f3_data_ff;

endmodule

// ----- hdl/delu_cell.sv -----
// ----------------------------------------------------------------------------
// DELU series cell
// One Horner step of the exponential series: p = 1 + (p * r) / DIVISOR.
// ----------------------------------------------------------------------------
module delu_cell #(
   parameter int DIVISOR = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  delu_pkg::delu_cell_data_type in_data,
   output logic                         out_valid,
   output delu_pkg::delu_cell_data_type out_data
);

   // Exact division by a small constant through a rounded-up reciprocal.
   localparam int SHIFT_L = $clog2(DIVISOR);
   localparam logic [63:0] MULT_WIDE =
      ((64'd1 << (32 + SHIFT_L)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [32:0] MULT = MULT_WIDE[32:0];

   logic                         a_valid_ff, b_valid_ff;
   logic [61:0]                  a_prod_ff;
   delu_pkg::delu_cell_data_type a_data_ff, b_data_ff, b_data_in;
   logic [64:0]                  q_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_comb begin
      q_wide      = 65'(a_prod_ff[61:30]) * 65'(MULT);
      b_data_in   = a_data_ff;
      b_data_in.p = delu_pkg::ONE_Q30 + 32'(q_wide >> (32 + SHIFT_L));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_prod_ff <= 62'(in_data.p) * 62'(in_data.r30);
         a_data_ff <= in_data;
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

// ----- hdl/delu_activation_unit.sv -----
// ----------------------------------------------------------------------------
// DELU activation unit
// Throughput: one element per cycle while the skid register is empty, set by
// the chain of series cells, each of which has two pipeline registers
// (multiply, then constant reciprocal).
// Reset clears all valid bits and loads the register defaults (a = 1.0,
// 1/b = 0.5, threshold about 1.25643); no clearing pass is needed.
// ----------------------------------------------------------------------------
module delu_activation_unit #(
   parameter int EXP_STAGES = 16
) (
   input  logic         clock,
   input  logic         reset,
   delu_req_if.sink     req_chan,
   delu_rsp_if.source   rsp_chan,
   delu_csr_if.sink     csr_chan
);

   // Configuration registers. Software must write them only while the unit is
   // idle, so every stage can read them directly; the block does not enforce it.
   logic signed [31:0] gain_a_ff, recip_b_ff, knee_ff;

   // The whole pipeline advances together; it freezes only while the skid
   // register holds a response, which keeps the ready path registered.
   logic en;

   logic                         chain_valid [EXP_STAGES+1];
   delu_pkg::delu_cell_data_type chain_data  [EXP_STAGES+1];

   // Back end: scaling by 2^k, product with 1/b and final clip.
   logic                    t0_valid_ff, t1_valid_ff, t2_valid_ff;
   delu_pkg::delu_side_type t0_side_ff, t1_side_ff;
   logic signed [32:0]      t0_em1_ff, t0_em1_in;
   logic                    t0_esat_ff, t0_esat_in, t1_esat_ff;
   logic signed [64:0]      t1_prod_ff;
   logic signed [31:0]      t2_res_ff, t2_res_in;
   logic                    t2_sat_ff, t2_sat_in, t2_last_ff;

   logic signed [7:0]  sc_shift;
   logic [7:0]         sc_neg;
   logic [63:0]        sc_value;
   logic               sc_over;
   logic signed [31:0] sc_exp;
   logic signed [48:0] fin_scaled;

   // Output register with a one-entry skid behind it.
   logic               out_valid_ff, skid_valid_ff;
   logic signed [31:0] out_res_ff, skid_res_ff;
   logic               out_sat_ff, skid_sat_ff;
   logic               out_last_ff, skid_last_ff;
   logic               out_free;

   assign en             = !skid_valid_ff;
   assign req_chan.ready = en;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_a_ff  <= delu_pkg::GAIN_A_RST;
         recip_b_ff <= delu_pkg::RECIP_B_RST;
         knee_ff    <= delu_pkg::KNEE_RST;
      end else if (csr_chan.valid) begin
         unique case (delu_pkg::csr_index_type'(csr_chan.index))
            delu_pkg::CSR_GAIN_A:  gain_a_ff  <= csr_chan.data;
            delu_pkg::CSR_RECIP_B: recip_b_ff <= csr_chan.data;
            delu_pkg::CSR_KNEE:    knee_ff    <= csr_chan.data;
            default: begin
               // Writes past the register list are dropped.
            end
         endcase
      end
   end

   // Front end: gain products, range reduction, and the backward result.
   delu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .in_cmd    (req_chan.cmd),
      .in_sample (req_chan.sample),
      .in_grad   (req_chan.grad_in),
      .in_last   (req_chan.last_in),
      .gain_a    (gain_a_ff),
      .recip_b   (recip_b_ff),
      .knee      (knee_ff),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   // Horner chain: the innermost term (largest divisor) comes first.
   for (genvar j = 0; j < EXP_STAGES; j++) begin : g_cell
      delu_cell #(
         .DIVISOR (EXP_STAGES - j)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_valid[j]),
         .in_data   (chain_data[j]),
         .out_valid (chain_valid[j+1]),
         .out_data  (chain_data[j+1])
      );
   end

   // Scale the series value by 2^k. A left shift never exceeds 31 places and a
   // right shift of 32 places or more leaves nothing.
   always_comb begin
      sc_shift = chain_data[EXP_STAGES].side.shift;
      sc_neg   = 8'(-sc_shift);
      if (sc_shift >= 0) begin
         sc_value = 64'(chain_data[EXP_STAGES].p) << sc_shift[4:0];
      end else begin
         sc_value = 64'(chain_data[EXP_STAGES].p) >> sc_neg[6:0];
      end
      sc_over = !chain_data[EXP_STAGES].side.zero && (sc_value > 64'(delu_pkg::VMAX));
      if (chain_data[EXP_STAGES].side.big || sc_over) begin
         sc_exp = delu_pkg::VMAX;
      end else if (chain_data[EXP_STAGES].side.zero) begin
         sc_exp = '0;
      end else begin
         sc_exp = sc_value[31:0];
      end
      t0_esat_in = chain_data[EXP_STAGES].side.big || sc_over;
      t0_em1_in  = 33'(sc_exp) - 33'(delu_pkg::ONE_Q);
   end

   // Final floor shift and clip; pass-through and backward results bypass it.
   always_comb begin
      fin_scaled = t1_prod_ff[64:16];
      if (t1_side_ff.done) begin
         t2_res_in = t1_side_ff.res;
         t2_sat_in = t1_side_ff.sat;
      end else if (fin_scaled > 49'(delu_pkg::VMAX)) begin
         t2_res_in = delu_pkg::VMAX;
         t2_sat_in = 1'b1;
      end else if (fin_scaled < 49'(delu_pkg::VMIN)) begin
         t2_res_in = delu_pkg::VMIN;
         t2_sat_in = 1'b1;
      end else begin
         t2_res_in = fin_scaled[31:0];
         t2_sat_in = t1_esat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_valid_ff <= 1'b0;
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
      end else if (en) begin
         t0_valid_ff <= chain_valid[EXP_STAGES];
         t1_valid_ff <= t0_valid_ff;
         t2_valid_ff <= t1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t0_side_ff <= chain_data[EXP_STAGES].side;
         t0_em1_ff  <= t0_em1_in;
         t0_esat_ff <= t0_esat_in;
         t1_side_ff <= t0_side_ff;
         t1_esat_ff <= t0_esat_ff;
         t1_prod_ff <= 65'(t0_em1_ff) * 65'(recip_b_ff);
         t2_res_ff  <= t2_res_in;
         t2_sat_ff  <= t2_sat_in;
         t2_last_ff <= t1_side_ff.last;
      end
   end

   // Response staging. The skid entry drains first; while it is full the
   // pipeline is frozen, so no new item can arrive at the same time.
   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (t2_valid_ff) begin
         if (out_free) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) begin
            out_res_ff  <= skid_res_ff;
            out_sat_ff  <= skid_sat_ff;
            out_last_ff <= skid_last_ff;
         end
      end else if (t2_valid_ff) begin
         if (out_free) begin
            out_res_ff  <= t2_res_ff;
            out_sat_ff  <= t2_sat_ff;
            out_last_ff <= t2_last_ff;
         end else begin
            skid_res_ff  <= t2_res_ff;
            skid_sat_ff  <= t2_sat_ff;
            skid_last_ff <= t2_last_ff;
         end
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.result    = out_res_ff;
   assign rsp_chan.saturated = out_sat_ff;
   assign rsp_chan.last_out  = out_last_ff;

   // The skid entry is only ever filled behind a waiting response.
   a_skid_behind_out: assert property (
      @(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff
   ) else $error("skid entry full while output register is empty");

   // A drained skid entry lands in the output register.
   a_skid_drain: assert property (
      @(posedge clock) disable iff (reset)
      $fell(skid_valid_ff) |-> out_valid_ff
   ) else $error("skid entry drained without a response");

   // An exponent known to overflow always ends up flagged, unless the result is already final.
   a_big_sat: assert property (
      @(posedge clock) disable iff (reset)
      (en && chain_valid[EXP_STAGES] && !chain_data[EXP_STAGES].side.done
          && chain_data[EXP_STAGES].side.big) |=> (t0_valid_ff && t0_esat_ff)
   ) else $error("overflowing exponent lost its saturation flag");

endmodule
